// ===== rtl/core/bls_pkg.sv =====
package bls_pkg;

	// payload widths fixed by the item format
	localparam int KIND_W  = 1;
	localparam int CIDX_W  = 4;
	localparam int COEF_W  = 16;
	localparam int SMP_W   = 16;
	localparam int LC_W    = 6;
	localparam int FRAC_W  = 14;
	localparam int PROD_W  = SMP_W + COEF_W + 1;
	localparam int SUM_W   = PROD_W + 1;
	localparam int COEF_SLOTS = 16;

	localparam logic [LC_W-1:0] LAYER_COUNT_RST = LC_W'(4);

	// item kind codes
	localparam logic [KIND_W-1:0] KIND_COEF   = 1'b0;
	localparam logic [KIND_W-1:0] KIND_SAMPLE = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic coef_wr;
		logic smp_wr;
		logic calc;
		logic src_bank;
	} bls_cmd_t;

endpackage

// ===== rtl/core/bls_if.sv =====
// input item channel
interface bls_in_if
	import bls_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic [CIDX_W-1:0]        coef_index;
	logic signed [COEF_W-1:0] coef_value;
	logic signed [SMP_W-1:0]  sample;

	modport source(output valid, kind, coef_index, coef_value, sample, input ready);
	modport sink(input valid, kind, coef_index, coef_value, sample, output ready);
endinterface

// result item channel
interface bls_out_if
	import bls_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] result;
	logic                    last;

	modport source(output valid, result, last, input ready);
	modport sink(input valid, result, last, output ready);
endinterface

// ===== rtl/core/bls_ram.sv =====
module bls_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== rtl/core/bls_dp.sv =====
module bls_dp
	import bls_pkg::*;
#(
	parameter int DIM = 16,
	localparam int IW = $clog2(DIM),
	localparam int K = $clog2(DIM + 1) - 1,
	localparam int SW = (K > 1) ? $clog2(K) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bls_cmd_t                 cmd,
	input  logic [IW-1:0]            idx,
	input  logic [SW-1:0]            shift,
	input  logic [CIDX_W-1:0]        coef_index,
	input  logic signed [COEF_W-1:0] coef_value,
	input  logic signed [SMP_W-1:0]  sample,
	output logic signed [SMP_W-1:0]  result
);

	localparam int CDEPTH = (DIM < COEF_SLOTS) ? DIM : COEF_SLOTS;
	localparam int CAW = $clog2(CDEPTH);
	localparam logic [IW:0] DIM_W = (IW + 1)'(DIM);

	// butterfly index generation for element idx at the current block size
	logic [SW:0]   sh1;
	logic [IW-1:0] bs, q, nb, blk, off, base, i1, i2, pa;
	logic          hi;

	always_comb begin
		sh1  = (SW + 1)'(shift) + (SW + 1)'(1);
		bs   = IW'(1) << shift;
		q    = idx >> sh1;
		nb   = IW'(DIM_W >> sh1);
		blk  = (q == nb) ? '0 : q;
		off  = idx & (bs - IW'(1));
		base = blk << sh1;
		i1   = base + off;
		i2   = i1 + bs;
		hi   = |(idx & bs);
		pa   = blk << 1;
	end

	// coefficient store, a at even slot, b at odd slot
	logic            coef_we;
	logic [CAW-1:0]  ca_addr, cb_addr;
	logic [COEF_W-1:0] ca_rd, cb_rd;

	assign coef_we = cmd.coef_wr && ({1'b0, coef_index} < (CIDX_W + 1)'(CDEPTH));
	assign ca_addr = pa[CAW-1:0];
	assign cb_addr = pa[CAW-1:0] | CAW'(1);

	bls_ram #(.WIDTH(COEF_W), .DEPTH(CDEPTH)) u_coef (
		.clk    (clk),
		.we     (coef_we),
		.waddr  (coef_index[CAW-1:0]),
		.wdata  (coef_value),
		.raddr_a(ca_addr),
		.rdata_a(ca_rd),
		.raddr_b(cb_addr),
		.rdata_b(cb_rd)
	);

	// two vector banks, one read while the other is written
	logic                    wr_s2, dst_s2;
	logic [IW-1:0]           f_s2;
	logic signed [SMP_W-1:0] y;
	logic                    we0, we1;
	logic [IW-1:0]           waddr, raddr_a;
	logic [SMP_W-1:0]        wdata;
	logic [SMP_W-1:0]        b0_rda, b0_rdb, b1_rda, b1_rdb;

	assign we0     = cmd.smp_wr || (wr_s2 && !dst_s2);
	assign we1     = wr_s2 && dst_s2;
	assign waddr   = cmd.smp_wr ? idx : f_s2;
	assign wdata   = cmd.smp_wr ? sample : y;
	assign raddr_a = cmd.calc ? i1 : idx;

	bls_ram #(.WIDTH(SMP_W), .DEPTH(DIM)) u_bank0 (
		.clk    (clk),
		.we     (we0),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.rdata_a(b0_rda),
		.raddr_b(i2),
		.rdata_b(b0_rdb)
	);

	bls_ram #(.WIDTH(SMP_W), .DEPTH(DIM)) u_bank1 (
		.clk    (clk),
		.we     (we1),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.rdata_a(b1_rda),
		.raddr_b(i2),
		.rdata_b(b1_rdb)
	);

	// stage 1 tracks the registered reads
	logic          v_s1, hi_s1, dst_s1;
	logic [IW-1:0] f_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			wr_s2 <= 1'b0;
		end else begin
			v_s1  <= cmd.calc;
			wr_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		hi_s1  <= hi;
		dst_s1 <= ~cmd.src_bank;
		f_s1   <= idx;
	end

	// stage 2 multiplies, low half a*x1 + b*x2, high half -b*x1 + a*x2
	logic signed [SMP_W-1:0]  x1, x2;
	logic signed [COEF_W:0]   ca, cb, c1, c2;
	logic signed [PROD_W-1:0] p1_s2, p2_s2;

	always_comb begin
		x1 = dst_s1 ? b0_rda : b1_rda;
		x2 = dst_s1 ? b0_rdb : b1_rdb;
		ca = (COEF_W + 1)'($signed(ca_rd));
		cb = (COEF_W + 1)'($signed(cb_rd));
		c1 = hi_s1 ? -cb : ca;
		c2 = hi_s1 ? ca : cb;
	end

	always_ff @(posedge clk) begin
		p1_s2  <= c1 * x1;
		p2_s2  <= c2 * x2;
		f_s2   <= f_s1;
		dst_s2 <= dst_s1;
	end

	// sum, floor shift and saturate on the way into the bank
	logic signed [SUM_W-1:0]          sum;
	logic signed [SUM_W-FRAC_W-1:0]   shr;

	always_comb begin
		sum = SUM_W'(p1_s2) + SUM_W'(p2_s2);
		shr = sum[SUM_W-1:FRAC_W];
		if (shr > (SUM_W - FRAC_W)'(32767)) begin
			y = 16'sh7fff;
		end else if (shr < -(SUM_W - FRAC_W)'(32768)) begin
			y = 16'sh8000;
		end else begin
			y = shr[SMP_W-1:0];
		end
	end

	// emitted element comes from port a of the bank holding the final vector
	assign result = cmd.src_bank ? b1_rda : b0_rda;

endmodule

// ===== rtl/core/bls_ctrl.sv =====
module bls_ctrl
	import bls_pkg::*;
#(
	parameter int DIM = 16,
	localparam int IW = $clog2(DIM),
	localparam int K = $clog2(DIM + 1) - 1,
	localparam int SW = (K > 1) ? $clog2(K) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [LC_W-1:0]   cfg_wdata,
	input  logic              in_valid,
	input  logic [KIND_W-1:0] in_kind,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_last,
	output bls_cmd_t          cmd,
	output logic [IW-1:0]     idx,
	output logic [SW-1:0]     shift
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LAYER,
		ST_DRAIN,
		ST_PRIME,
		ST_EMIT
	} state_t;

	localparam logic [IW-1:0] LAST_IDX = IW'(DIM - 1);
	localparam logic [SW-1:0] LAST_SHIFT = SW'(K - 1);

	state_t          state_q;
	logic [IW-1:0]   idx_q;
	logic [LC_W-1:0] layer_q;
	logic [LC_W-1:0] layer_count_q;
	logic [SW-1:0]   shift_q;
	logic            drain_q;
	logic            src_q;
	logic            in_fire;
	logic            at_last;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign at_last  = (idx_q == LAST_IDX);

	// sequencer: load, layers with pipeline drain, prime read, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			idx_q         <= '0;
			layer_q       <= '0;
			layer_count_q <= LAYER_COUNT_RST;
			shift_q       <= '0;
			drain_q       <= 1'b0;
			src_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				layer_count_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire && (in_kind == KIND_SAMPLE)) begin
						if (at_last) begin
							idx_q   <= '0;
							layer_q <= '0;
							shift_q <= '0;
							src_q   <= 1'b0;
							state_q <= (layer_count_q == '0) ? ST_PRIME : ST_LAYER;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				ST_LAYER: begin
					if (at_last) begin
						idx_q   <= '0;
						drain_q <= 1'b0;
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_DRAIN: begin
					if (drain_q) begin
						src_q   <= ~src_q;
						shift_q <= (shift_q == LAST_SHIFT) ? '0 : shift_q + SW'(1);
						if ((layer_q + LC_W'(1)) == layer_count_q) begin
							layer_q <= '0;
							state_q <= ST_PRIME;
						end else begin
							layer_q <= layer_q + LC_W'(1);
							state_q <= ST_LAYER;
						end
					end else begin
						drain_q <= 1'b1;
					end
				end
				ST_PRIME: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_ready) begin
						if (at_last) begin
							idx_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// read address runs one ahead on an accepted beat
	always_comb begin
		idx = idx_q;
		if ((state_q == ST_EMIT) && out_ready && !at_last) begin
			idx = idx_q + IW'(1);
		end
	end

	// command decode
	always_comb begin
		cmd.coef_wr  = in_fire && (in_kind == KIND_COEF);
		cmd.smp_wr   = in_fire && (in_kind == KIND_SAMPLE);
		cmd.calc     = (state_q == ST_LAYER);
		cmd.src_bank = src_q;
	end

	assign shift     = shift_q;
	assign out_valid = (state_q == ST_EMIT);
	assign out_last  = at_last;

endmodule

// ===== rtl/core/butterfly_layer_stack.sv =====
// Butterfly layer stack: collects DIM samples, runs layer_count butterfly layers over them
// with the coefficient store, and sends the DIM results with last on the final beat.
// Coefficient beats are taken while the block is idle. A vector costs DIM sample beats,
// then per layer DIM butterfly outputs at one per cycle followed by a drain of the
// read-multiply-write pipeline before the next layer reads its input bank, then a prime
// of the output read, and DIM result beats at one per cycle when the sink is ready.
// Inputs are held off from the last sample until the last result beat is taken.
// layer_count resets to 4 and may be written only while the block is idle.
module butterfly_layer_stack
	import bls_pkg::*;
#(
	parameter int DIM = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [LC_W-1:0] cfg_wdata,
	bls_in_if.sink          items,
	bls_out_if.source       results
);

	localparam int IW = $clog2(DIM);
	localparam int K = $clog2(DIM + 1) - 1;
	localparam int SW = (K > 1) ? $clog2(K) : 1;

	bls_cmd_t      cmd;
	logic [IW-1:0] idx;
	logic [SW-1:0] shift;

	// sequencing and handshakes
	bls_ctrl #(.DIM(DIM)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (items.valid),
		.in_kind  (items.kind),
		.in_ready (items.ready),
		.out_valid(results.valid),
		.out_ready(results.ready),
		.out_last (results.last),
		.cmd      (cmd),
		.idx      (idx),
		.shift    (shift)
	);

	// stores and butterfly arithmetic
	bls_dp #(.DIM(DIM)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.idx       (idx),
		.shift     (shift),
		.coef_index(items.coef_index),
		.coef_value(items.coef_value),
		.sample    (items.sample),
		.result    (results.result)
	);

endmodule
